@@ rtl/sti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_pkg: shared types and codes of the sorted table
// Operation and status codes, field widths, and the control word broadcast
// to every cell of the table.
// ----------------------------------------------------------------------------
package sti_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic   load;
        logic   write;
        value_t value;
    } cell_ctrl_t;

endpackage

@@ rtl/sti_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_req_if: request channel of the sorted table
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface sti_req_if;

    logic            valid;
    logic            ready;
    logic            opcode;
    sti_pkg::value_t value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);

endinterface

@@ rtl/sti_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_rsp_if: response channel of the sorted table
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface sti_rsp_if;

    logic                          valid;
    logic                          ready;
    logic                          found;
    logic                          status;
    logic [sti_pkg::COUNT_W-1:0]   entry_count;

    modport source (output valid, output found, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input found, input status, input entry_count,
                    output ready);

endinterface

@@ rtl/sti_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_cell: one slot of the sorted table
// Holds one entry, compares it with the broadcast value, and on an insert
// either keeps it, takes the new value, or takes the left neighbor's entry.
// ----------------------------------------------------------------------------
module sti_cell
(
    input  logic                clk,
    input  sti_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  sti_pkg::value_t     left_entry,
    input  logic                left_after,
    output sti_pkg::value_t     entry,
    output logic                after,
    output logic                match
);

    sti_pkg::value_t entry_reg;
    sti_pkg::value_t entry_next;
    logic            match_reg;
    logic            match_next;

    // at or past the insert position: empty, or strictly greater than value
    assign after = !occupied || (ctrl.value < entry_reg);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.write && after)
        begin
            entry_next = left_after ? left_entry : ctrl.value;
        end
        match_next = match_reg;
        if (ctrl.load)
        begin
            match_next = occupied && (entry_reg == ctrl.value);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

@@ rtl/sorted_table_insert_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_search_top: sorted table with insert and search
// Keeps up to TABLE_DEPTH signed 32-bit entries in ascending order in a row
// of cells.
//
// Usage:
//   req carries one word per operation: opcode (insert or search) and value.
//   rsp returns one word per operation: found (search hit), status (insert
//   dropped because the table was full) and entry_count after the operation.
//   An insert lands after any equal entries; each cell compares its entry
//   with the broadcast value and shifts right in the same cycle, so the
//   table is updated at the edge the word is accepted.
//   From accept to rsp valid, every cell first registers its equality match,
//   then the OR of those matches goes into the output register. One word is
//   accepted per cycle while rsp is drained.
//   Reset empties the table (count to zero) and clears both pipeline stages.
//   When rsp stalls, the output register and the match stage hold, and req
//   is held off once both are full.
// ----------------------------------------------------------------------------
module sorted_table_insert_search_top
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    sti_req_if.sink    req,
    sti_rsp_if.source  rsp
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          s1_op_reg;
    logic          s1_status_reg;
    logic [CW-1:0] s1_count_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_found_reg;
    logic          out_status_reg;
    logic [CW-1:0] out_count_reg;

    logic                 accept;
    logic                 full;
    logic                 out_free;
    logic                 s1_free;
    sti_pkg::cell_ctrl_t  ctrl;
    sti_pkg::value_t      entries [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] after_vec;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] occ_vec;

    assign full     = (count_reg >= CW'(TABLE_DEPTH));
    assign out_free = !out_valid_reg || rsp.ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign req.ready = s1_free;
    assign accept   = req.valid && req.ready;

    assign ctrl.load  = accept;
    assign ctrl.write = accept && (req.opcode == sti_pkg::OP_INSERT) && !full;
    assign ctrl.value = req.value;

    genvar i;
    generate
        for (i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            assign occ_vec[i] = (CW'(i) < count_reg);
            if (i == 0)
            begin : g_first
                sti_cell u_cell
                (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .occupied   (occ_vec[i]),
                    .left_entry (req.value),
                    .left_after (1'b0),
                    .entry      (entries[i]),
                    .after      (after_vec[i]),
                    .match      (match_vec[i])
                );
            end
            else
            begin : g_rest
                sti_cell u_cell
                (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .occupied   (occ_vec[i]),
                    .left_entry (entries[i-1]),
                    .left_after (after_vec[i-1]),
                    .entry      (entries[i]),
                    .after      (after_vec[i]),
                    .match      (match_vec[i])
                );
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.write)
        begin
            count_next = count_reg + CW'(1);
        end
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= req.opcode;
            s1_status_reg <= (req.opcode == sti_pkg::OP_INSERT && full) ?
                             sti_pkg::STATUS_FULL : sti_pkg::STATUS_OK;
            s1_count_reg  <= count_next;
        end
        if (out_free && s1_valid_reg)
        begin
            out_found_reg  <= (s1_op_reg == sti_pkg::OP_SEARCH) && (|match_vec);
            out_status_reg <= s1_status_reg;
            out_count_reg  <= s1_count_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_count = sti_pkg::COUNT_W'(out_count_reg);

    logic [TABLE_DEPTH-1:0] order_ok;
    generate
        for (i = 0; i < TABLE_DEPTH; i++)
        begin : g_order
            if (i == 0)
            begin : g_first
                assign order_ok[i] = 1'b1;
            end
            else
            begin : g_rest
                assign order_ok[i] = !occ_vec[i] || (entries[i-1] <= entries[i]);
            end
        end
    endgenerate

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.opcode == sti_pkg::OP_INSERT && !full
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the table");

    a_search_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.opcode == sti_pkg::OP_SEARCH |=> $stable(count_reg))
        else $error("search changed the table size");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !rsp.ready |-> !req.ready)
        else $error("request taken with both stages full");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        &order_ok)
        else $error("table entries out of order");

endmodule

@@ dv/tb_sorted_table_insert_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_insert_search_top: self-checking bench for the sorted table
// Drives insert and search words on req with bursty gaps, stalls rsp on
// shifting patterns, and checks every response against a shadow copy of the
// sorted table. A short directed sweep covers the extremes and duplicates;
// the random part fills the table slowly, then hammers the full table.
// ----------------------------------------------------------------------------
module tb_sorted_table_insert_search_top;

    localparam int TABLE_DEPTH  = 64;
    localparam int RANDOM_WORDS = 1500;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    localparam sti_pkg::value_t VALUE_MIN = 32'sh8000_0000;
    localparam sti_pkg::value_t VALUE_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                        found;
        logic                        status;
        logic [sti_pkg::COUNT_W-1:0] entry_count;
    } rsp_word_t;

    logic clk = 1'b0;
    logic rst_n;

    sti_req_if req_ch ();
    sti_rsp_if rsp_ch ();

    sorted_table_insert_search_top #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sti_pkg::value_t shadow_entries [TABLE_DEPTH];
    int              shadow_count = 0;
    rsp_word_t       expected_q [$];

    int cyc          = 0;
    int fail_count   = 0;
    int rsp_count    = 0;
    int n_insert     = 0;
    int n_dropped    = 0;
    int n_search     = 0;
    int n_hits       = 0;
    int burst_left   = 0;
    int stall_mode   = 0;

    function automatic rsp_word_t table_apply(input logic op, input sti_pkg::value_t v);
        rsp_word_t w;
        int        pos;
        w.found  = 1'b0;
        w.status = sti_pkg::STATUS_OK;
        if (op == sti_pkg::OP_INSERT)
        begin
            n_insert++;
            if (shadow_count >= TABLE_DEPTH)
            begin
                w.status = sti_pkg::STATUS_FULL;
                n_dropped++;
            end
            else
            begin
                pos = shadow_count;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (v < shadow_entries[i])
                    begin
                        pos = i;
                        break;
                    end
                end
                for (int i = shadow_count; i > pos; i--)
                    shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[pos] = v;
                shadow_count++;
            end
        end
        else
        begin
            n_search++;
            for (int i = 0; i < shadow_count; i++)
            begin
                if (shadow_entries[i] == v)
                    w.found = 1'b1;
            end
            if (w.found)
                n_hits++;
        end
        w.entry_count = shadow_count[sti_pkg::COUNT_W-1:0];
        return w;
    endfunction

    task automatic send_word(input logic op, input sti_pkg::value_t v, input bit known,
                             input rsp_word_t want);
        rsp_word_t predicted;
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.value  <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = table_apply(op, v);
        expected_q.push_back(known ? want : predicted);
    endtask

    // receiver stall patterns, reshuffled at random
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 97 == 0)
            stall_mode <= $urandom_range(0, 4);
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            3:       rsp_ch.ready <= ((cyc % 7) >= 3);
            default: rsp_ch.ready <= ((cyc % 23) >= 15);
        endcase
    end

    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_count++;
            if (expected_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("[%0t] unexpected rsp word: found=%0b status=%0b count=%0d",
                             $realtime, rsp_ch.found, rsp_ch.status, rsp_ch.entry_count);
            end
            else
            begin
                want = expected_q.pop_front();
                if (rsp_ch.found !== want.found || rsp_ch.status !== want.status ||
                    rsp_ch.entry_count !== want.entry_count)
                begin
                    fail_count++;
                    // found/status/count
                    if (fail_count <= REPORT_MAX)
                        $display("[%0t] rsp %0d: expected %0b/%0b/%0d, got %0b/%0b/%0d",
                                 $realtime, rsp_count, want.found, want.status,
                                 want.entry_count, rsp_ch.found, rsp_ch.status,
                                 rsp_ch.entry_count);
                end
            end
        end
    end

    initial
    begin
        while (cyc < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d words outstanding", cyc, expected_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    typedef struct {
        logic            op;
        sti_pkg::value_t value;
        bit              known;
        rsp_word_t       want;
    } stim_row_t;

    stim_row_t directed_rows [$];

    function automatic void add_row(input logic op, input sti_pkg::value_t v, input bit known,
                                    input logic found, input logic status, input int count);
        stim_row_t r;
        r.op                 = op;
        r.value              = v;
        r.known              = known;
        r.want.found         = found;
        r.want.status        = status;
        r.want.entry_count   = count[sti_pkg::COUNT_W-1:0];
        directed_rows.push_back(r);
    endfunction

    initial
    begin
        logic            op;
        sti_pkg::value_t v;
        int              pick;
        int              ins_pct;
        rsp_word_t       blank;

        blank         = '0;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = sti_pkg::OP_INSERT;
        req_ch.value  = '0;
        rsp_ch.ready  = 1'b0;

        add_row(sti_pkg::OP_SEARCH, 0,             1'b1, 1'b0, sti_pkg::STATUS_OK, 0);
        add_row(sti_pkg::OP_INSERT, VALUE_MAX,     1'b1, 1'b0, sti_pkg::STATUS_OK, 1);
        add_row(sti_pkg::OP_INSERT, VALUE_MIN,     1'b1, 1'b0, sti_pkg::STATUS_OK, 2);
        add_row(sti_pkg::OP_SEARCH, VALUE_MIN,     1'b1, 1'b1, sti_pkg::STATUS_OK, 2);
        add_row(sti_pkg::OP_SEARCH, VALUE_MAX,     1'b1, 1'b1, sti_pkg::STATUS_OK, 2);
        add_row(sti_pkg::OP_SEARCH, 0,             1'b1, 1'b0, sti_pkg::STATUS_OK, 2);
        add_row(sti_pkg::OP_INSERT, 0,             1'b1, 1'b0, sti_pkg::STATUS_OK, 3);
        add_row(sti_pkg::OP_INSERT, 0,             1'b1, 1'b0, sti_pkg::STATUS_OK, 4);
        add_row(sti_pkg::OP_INSERT, -1,            1'b1, 1'b0, sti_pkg::STATUS_OK, 5);
        add_row(sti_pkg::OP_SEARCH, -1,            1'b1, 1'b1, sti_pkg::STATUS_OK, 5);
        add_row(sti_pkg::OP_SEARCH, 1,             1'b1, 1'b0, sti_pkg::STATUS_OK, 5);
        add_row(sti_pkg::OP_INSERT, VALUE_MIN,     1'b1, 1'b0, sti_pkg::STATUS_OK, 6);
        add_row(sti_pkg::OP_SEARCH, VALUE_MAX - 1, 1'b1, 1'b0, sti_pkg::STATUS_OK, 6);
        add_row(sti_pkg::OP_SEARCH, VALUE_MIN + 1, 1'b1, 1'b0, sti_pkg::STATUS_OK, 6);
        add_row(sti_pkg::OP_INSERT, 32'sh5555_aaaa, 1'b0, 1'b0, sti_pkg::STATUS_OK, 0);
        add_row(sti_pkg::OP_INSERT, 32'sh5555_aaab, 1'b0, 1'b0, sti_pkg::STATUS_OK, 0);
        add_row(sti_pkg::OP_SEARCH, 32'sh5555_aaaa, 1'b0, 1'b0, sti_pkg::STATUS_OK, 0);
        add_row(sti_pkg::OP_SEARCH, 32'shaaaa_5555, 1'b0, 1'b0, sti_pkg::STATUS_OK, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].value, directed_rows[i].known,
                      directed_rows[i].want);

        // fill slowly while searching, then keep pushing inserts at the full table
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            ins_pct = (shadow_count < TABLE_DEPTH) ? 12 : 30;
            op      = ($urandom_range(0, 99) < ins_pct) ? sti_pkg::OP_INSERT
                                                        : sti_pkg::OP_SEARCH;
            pick    = $urandom_range(0, 9);
            if (pick < 3 && shadow_count > 0)
                v = shadow_entries[$urandom_range(0, shadow_count - 1)];
            else if (pick == 3 && shadow_count > 0)
                v = shadow_entries[$urandom_range(0, shadow_count - 1)]
                    + ($urandom_range(0, 1) ? 1 : -1);
            else if (pick < 6)
                v = sti_pkg::value_t'($urandom_range(0, 8)) - 4;
            else if (pick == 6)
            begin
                case ($urandom_range(0, 3))
                    0:       v = VALUE_MIN;
                    1:       v = VALUE_MAX;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            else
                v = $urandom;
            send_word(op, v, 1'b0, blank);
        end

        req_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d responses: %0d inserts (%0d dropped when full)",
                 rsp_count, n_insert, n_dropped);
        $display("%0d searches (%0d hits), final occupancy %0d of %0d, %0d mismatches",
                 n_search, n_hits, shadow_count, TABLE_DEPTH, fail_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sti_pkg.sv
rtl/sti_req_if.sv
rtl/sti_rsp_if.sv
rtl/sti_cell.sv
rtl/sorted_table_insert_search_top.sv
dv/tb_sorted_table_insert_search_top.sv
